// ===== sv/vmfe_pkg.sv =====
// vmfe_pkg: shared constants, types and a function for the view matrix block.
// Holds the CORDIC arctangent table. No dependencies.
package vmfe_pkg;

   localparam int ANGLE_BITS_DEF     = 16;
   localparam int COEF_FRAC_BITS_DEF = 14;
   localparam int CORDIC_STEPS       = 30;
   localparam int ANGLE_W            = 16;
   localparam int POS_W              = 32;
   localparam int COEF_W             = 16;
   localparam int TRANS_W            = 32;
   localparam int CW                 = 34;   // CORDIC x/y datapath width
   localparam int ZW                 = 34;   // CORDIC angle width
   localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
   localparam int REQ_DATA_W = 144;          // 3*16 + 3*32
   localparam int RSP_DATA_W = 240;          // 9*16 + 3*32

   typedef logic signed [CW-1:0] cord_type;
   typedef logic signed [ZW-1:0] zang_type;

   typedef struct packed {
      cord_type x;
      cord_type y;
      zang_type z;
      logic     flip;
   } cordic_lane_type;

   function automatic zang_type atan_turn(input int i);
      logic [31:0] t;
      case (i)
         0:  t = 32'h20000000;  1:  t = 32'h12E4051E;  2:  t = 32'h09FB385B;
         3:  t = 32'h051111D4;  4:  t = 32'h028B0D43;  5:  t = 32'h0145D7E1;
         6:  t = 32'h00A2F61E;  7:  t = 32'h00517C55;  8:  t = 32'h0028BE53;
         9:  t = 32'h00145F2F;  10: t = 32'h000A2F98;  11: t = 32'h000517CC;
         12: t = 32'h00028BE6;  13: t = 32'h000145F3;  14: t = 32'h0000A2F9;
         15: t = 32'h0000517C;  16: t = 32'h000028BE;  17: t = 32'h0000145F;
         18: t = 32'h00000A2F;  19: t = 32'h00000517;  20: t = 32'h0000028B;
         21: t = 32'h00000145;  22: t = 32'h000000A2;  23: t = 32'h00000051;
         24: t = 32'h00000028;  25: t = 32'h00000014;  26: t = 32'h0000000A;
         27: t = 32'h00000005;  28: t = 32'h00000002;  29: t = 32'h00000001;
         default: t = 32'h0;
      endcase
      return zang_type'({2'b00, t});
   endfunction

endpackage

// ===== sv/vmfe_cell.sv =====
// vmfe_cell: one CORDIC rotation step for the three angle lanes.
// Depends on vmfe_pkg. Registered stage with valid and stall.
module vmfe_cell #(
   parameter int STEP = 0
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic                          in_valid,
   input  vmfe_pkg::cordic_lane_type     in_lane [3],
   input  logic [vmfe_pkg::POS_W*3-1:0]  in_pos,
   output logic                          out_valid,
   output vmfe_pkg::cordic_lane_type     out_lane [3],
   output logic [vmfe_pkg::POS_W*3-1:0]  out_pos
);
   import vmfe_pkg::*;

   cordic_lane_type lane_ff [3];
   cordic_lane_type lane_in [3];
   logic [POS_W*3-1:0] pos_ff;
   logic valid_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         lane_in[k].flip = in_lane[k].flip;
         // arithmetic shift is floor division
         if (!in_lane[k].z[ZW-1]) begin
            lane_in[k].x = in_lane[k].x - (in_lane[k].y >>> STEP);
            lane_in[k].y = in_lane[k].y + (in_lane[k].x >>> STEP);
            lane_in[k].z = in_lane[k].z - atan_turn(STEP);
         end else begin
            lane_in[k].x = in_lane[k].x + (in_lane[k].y >>> STEP);
            lane_in[k].y = in_lane[k].y - (in_lane[k].x >>> STEP);
            lane_in[k].z = in_lane[k].z + atan_turn(STEP);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
      if (advance) begin
         lane_ff <= lane_in;
         pos_ff  <= in_pos;
      end
   end

   assign out_valid = valid_ff;
   assign out_lane  = lane_ff;
   assign out_pos   = pos_ff;
endmodule

// ===== sv/vmfe_basis.sv =====
// vmfe_basis: rounds CORDIC results to coefficients, forms basis vectors and
// translation terms over a short stall-aware pipeline. Depends on vmfe_pkg.
module vmfe_basis #(
   parameter int COEF_FRAC_BITS = vmfe_pkg::COEF_FRAC_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           advance,
   input  logic                           in_valid,
   input  vmfe_pkg::cordic_lane_type      in_lane [3],
   input  logic [vmfe_pkg::POS_W*3-1:0]   in_pos,
   output logic                           out_valid,
   output logic [vmfe_pkg::RSP_DATA_W-1:0] out_data
);
   import vmfe_pkg::*;

   localparam int SH   = 30 - COEF_FRAC_BITS;
   localparam int KW   = COEF_FRAC_BITS + 2;     // coefficient width
   localparam int PW   = 2 * KW;                 // product width
   localparam int DW   = KW + POS_W + 2;         // dot product width
   localparam logic signed [KW-1:0] ONE = KW'(1) <<< COEF_FRAC_BITS;
   localparam logic signed [DW-1:0] TMAX = DW'(64'sd2147483647);
   localparam logic signed [DW-1:0] TMIN = -DW'(64'sd2147483648);

   typedef logic signed [KW-1:0] coef_type;

   function automatic coef_type cordic_round(input cord_type v, input logic flip);
      logic signed [CW:0] t;
      logic signed [CW:0] r;
      t = flip ? -{v[CW-1], v} : {v[CW-1], v};
      r = (t + ((CW+1)'(1) <<< (SH - 1))) >>> SH;
      if (r > (CW+1)'(ONE)) return ONE;
      if (r < -(CW+1)'(ONE)) return -ONE;
      return coef_type'(r);
   endfunction

   function automatic coef_type cmul(input coef_type a, input coef_type b);
      logic signed [PW-1:0] p;
      p = PW'(a) * PW'(b);
      return coef_type'((p + (PW'(1) <<< (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS);
   endfunction

   function automatic coef_type cclamp(input logic signed [KW:0] v);
      if (v > (KW+1)'(ONE)) return ONE;
      if (v < -(KW+1)'(ONE)) return -ONE;
      return coef_type'(v);
   endfunction

   function automatic logic signed [TRANS_W-1:0] tsat(input logic signed [DW-1:0] d);
      logic signed [DW-1:0] r;
      r = (-d + (DW'(1) <<< (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
      if (r > TMAX) return TRANS_W'(32'sh7FFFFFFF);
      if (r < TMIN) return TRANS_W'(32'sh80000000);
      return TRANS_W'(r);
   endfunction

   // stage A: sin/cos and first products
   coef_type s1_ff, c1_ff, s2_ff, c2_ff, s3_ff, c3_ff;
   coef_type s12_ff, c1s2_ff;
   logic [POS_W*3-1:0] pa_ff;
   logic va_ff;
   // stage B: basis
   coef_type b_ff [9];
   logic [POS_W*3-1:0] pb_ff;
   logic vb_ff;
   // stage C: position products
   logic signed [DW-1:0] m_ff [9];
   coef_type bc_ff [9];
   logic vc_ff;
   // stage D: output
   logic [RSP_DATA_W-1:0] d_ff;
   logic vd_ff;

   coef_type s1_in, c1_in, s2_in, c2_in, s3_in, c3_in;
   coef_type b_in [9];

   always_comb begin
      // yaw is lane 1, pitch lane 0, roll lane 2
      s1_in = cordic_round(in_lane[1].y, in_lane[1].flip);
      c1_in = cordic_round(in_lane[1].x, in_lane[1].flip);
      s2_in = cordic_round(in_lane[0].y, in_lane[0].flip);
      c2_in = cordic_round(in_lane[0].x, in_lane[0].flip);
      s3_in = cordic_round(in_lane[2].y, in_lane[2].flip);
      c3_in = cordic_round(in_lane[2].x, in_lane[2].flip);
      b_in[0] = cclamp((KW+1)'(cmul(c1_ff, c3_ff)) + (KW+1)'(cmul(s12_ff, s3_ff)));
      b_in[1] = cclamp((KW+1)'(cmul(c2_ff, s3_ff)));
      b_in[2] = cclamp((KW+1)'(cmul(c1s2_ff, s3_ff)) - (KW+1)'(cmul(c3_ff, s1_ff)));
      b_in[3] = cclamp((KW+1)'(cmul(s12_ff, c3_ff)) - (KW+1)'(cmul(c1_ff, s3_ff)));
      b_in[4] = cclamp((KW+1)'(cmul(c2_ff, c3_ff)));
      b_in[5] = cclamp((KW+1)'(cmul(c1s2_ff, c3_ff)) + (KW+1)'(cmul(s1_ff, s3_ff)));
      b_in[6] = cclamp((KW+1)'(cmul(c2_ff, s1_ff)));
      b_in[7] = cclamp(-(KW+1)'(s2_ff));
      b_in[8] = cclamp((KW+1)'(cmul(c1_ff, c2_ff)));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
         vd_ff <= 1'b0;
      end else if (advance) begin
         va_ff <= in_valid;
         vb_ff <= va_ff;
         vc_ff <= vb_ff;
         vd_ff <= vc_ff;
      end
      if (advance) begin
         s1_ff <= s1_in; c1_ff <= c1_in;
         s2_ff <= s2_in; c2_ff <= c2_in;
         s3_ff <= s3_in; c3_ff <= c3_in;
         s12_ff  <= cmul(s1_in, s2_in);
         c1s2_ff <= cmul(c1_in, s2_in);
         pa_ff <= in_pos;
         b_ff  <= b_in;
         pb_ff <= pa_ff;
         bc_ff <= b_ff;
         for (int k = 0; k < 9; k++) begin
            m_ff[k] <= DW'(b_ff[k]) *
                       DW'($signed(pb_ff[(k%3)*POS_W +: POS_W]));
         end
         for (int k = 0; k < 9; k++) begin
            d_ff[k*COEF_W +: COEF_W] <= COEF_W'(bc_ff[k]);
         end
         for (int r = 0; r < 3; r++) begin
            d_ff[9*COEF_W + r*TRANS_W +: TRANS_W] <=
               tsat(m_ff[3*r] + m_ff[3*r+1] + m_ff[3*r+2]);
         end
      end
   end

   assign out_valid = vd_ff;
   assign out_data  = d_ff;

   always_ff @(posedge clock) begin
      if (!reset && vb_ff) begin
         assert (b_ff[4] <= ONE && b_ff[4] >= -ONE)
            else $error("basis entry out of range");
      end
   end
endmodule

// ===== sv/view_matrix_from_euler.sv =====
// Builds a camera view matrix (three Y-X-Z basis vectors in Q1.14 and a
// saturated Q16.16 translation) from three binary angles and a position.
// One pose is accepted per clock cycle while the output is not stalled; each
// pose passes through the 30 CORDIC cells in a row and then four stages of
// products, dot product and rounding. The whole pipe stalls while rsp_tready
// is low and a result waits. No state carries from one pose to the next.
module view_matrix_from_euler #(
   parameter int ANGLE_BITS     = vmfe_pkg::ANGLE_BITS_DEF,
   parameter int COEF_FRAC_BITS = vmfe_pkg::COEF_FRAC_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // angle_x, angle_y, angle_z, pos_x, pos_y, pos_z
   input  logic [vmfe_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // right_x..z, upv_x..z, fwd_x..z, trans_x, trans_y, trans_z
   output logic [vmfe_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import vmfe_pkg::*;

   localparam logic signed [ZW-1:0] QUARTER = ZW'(34'sd1073741824);
   localparam logic signed [ZW-1:0] HALF    = ZW'(34'sd2147483648);

   logic advance;
   logic v_chain [CORDIC_STEPS+1];
   cordic_lane_type l_chain [CORDIC_STEPS+1][3];
   logic [POS_W*3-1:0] p_chain [CORDIC_STEPS+1];

   assign advance    = !rsp_tvalid || rsp_tready;
   assign req_tready = advance;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         logic [ANGLE_BITS-1:0] a;
         zang_type z;
         a = req_tdata[k*ANGLE_W +: ANGLE_BITS];
         z = ZW'($signed({a, {(32-ANGLE_BITS){1'b0}}}));
         l_chain[0][k].x = CORDIC_GAIN;
         l_chain[0][k].y = '0;
         l_chain[0][k].flip = 1'b0;
         if (z > QUARTER) begin
            z = z - HALF;
            l_chain[0][k].flip = 1'b1;
         end else if (z < -QUARTER) begin
            z = z + HALF;
            l_chain[0][k].flip = 1'b1;
         end
         l_chain[0][k].z = z;
      end
   end

   assign v_chain[0] = req_tvalid;
   assign p_chain[0] = req_tdata[3*ANGLE_W +: 3*POS_W];

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
      vmfe_cell #(.STEP(i)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (v_chain[i]),
         .in_lane   (l_chain[i]),
         .in_pos    (p_chain[i]),
         .out_valid (v_chain[i+1]),
         .out_lane  (l_chain[i+1]),
         .out_pos   (p_chain[i+1])
      );
   end

   vmfe_basis #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_basis (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (v_chain[CORDIC_STEPS]),
      .in_lane   (l_chain[CORDIC_STEPS]),
      .in_pos    (p_chain[CORDIC_STEPS]),
      .out_valid (rsp_tvalid),
      .out_data  (rsp_tdata)
   );

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("result changed while stalled");
   assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("input ready does not follow output side");
endmodule
